// ===== sv/terminal_key_escape_decoder_top_defines.svh =====
// assertion macros for the terminal key escape decoder
`ifndef TERMINAL_KEY_ESCAPE_DECODER_TOP_DEFINES_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TKED_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define TKED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tked_pkg.sv =====
// shared types and constants of the terminal key escape decoder
`default_nettype none

package tked_pkg;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_OH      = 8'h4F;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [3:0] {
    KEY_PLAIN = 4'd0,
    KEY_UP    = 4'd1,
    KEY_DOWN  = 4'd2,
    KEY_RIGHT = 4'd3,
    KEY_LEFT  = 4'd4,
    KEY_DEL   = 4'd5,
    KEY_HOME  = 4'd6,
    KEY_END   = 4'd7,
    KEY_PGUP  = 4'd8,
    KEY_PGDN  = 4'd9,
    KEY_ESC   = 4'd10,
    KEY_UNK2  = 4'd11,
    KEY_UNK3  = 4'd12
  } key_kind_e;

  typedef struct packed {
    key_kind_e  kind;
    logic [7:0] key_byte;
  } tked_key_t;

  typedef struct packed {
    logic      vld;
    tked_key_t key;
  } tked_res_t;

endpackage

`default_nettype wire

// ===== sv/tked_parser.sv =====
// escape sequence state and per-beat key decode
`default_nettype none

module tked_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              timeout_i,
  input  logic [7:0]        rx_byte_i,
  output tked_pkg::tked_res_t res_o
);
  import tked_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_ONE  = 2'd2,
    PH_DIG  = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;

  function automatic key_kind_e bracket_letter(input logic [7:0] b);
    key_kind_e k;
    unique case (b)
      8'h41:   k = KEY_UP;
      8'h42:   k = KEY_DOWN;
      8'h43:   k = KEY_RIGHT;
      8'h44:   k = KEY_LEFT;
      8'h46:   k = KEY_END;
      8'h48:   k = KEY_HOME;
      default: k = KEY_UNK3;
    endcase
    return k;
  endfunction

  function automatic key_kind_e tilde_digit(input logic [7:0] d);
    key_kind_e k;
    unique case (d)
      8'h31:   k = KEY_HOME;
      8'h33:   k = KEY_DEL;
      8'h34:   k = KEY_END;
      8'h35:   k = KEY_PGUP;
      8'h36:   k = KEY_PGDN;
      8'h37:   k = KEY_HOME;
      8'h38:   k = KEY_END;
      default: k = KEY_UNK3;
    endcase
    return k;
  endfunction

  always_comb begin
    phase_d          = phase_q;
    first_d          = first_q;
    second_d         = second_q;
    res_o.vld        = 1'b0;
    res_o.key.kind   = KEY_PLAIN;
    res_o.key.key_byte = 8'h00;
    if (accept_i) begin
      if (timeout_i) begin
        phase_d = PH_IDLE;
        unique case (phase_q)
          PH_ESC: begin
            res_o.vld      = 1'b1;
            res_o.key.kind = KEY_ESC;
          end
          PH_ONE: begin
            res_o.vld      = 1'b1;
            res_o.key.kind = KEY_UNK2;
          end
          PH_DIG: begin
            res_o.vld          = 1'b1;
            res_o.key.key_byte = CH_ESC;
          end
          default: ;
        endcase
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (rx_byte_i == CH_ESC) begin
              phase_d = PH_ESC;
            end else begin
              res_o.vld          = 1'b1;
              res_o.key.key_byte = rx_byte_i;
            end
          end
          PH_ESC: begin
            first_d = rx_byte_i;
            phase_d = PH_ONE;
          end
          PH_ONE: begin
            second_d = rx_byte_i;
            phase_d  = PH_IDLE;
            if (first_q == CH_BRACKET) begin
              if (rx_byte_i >= CH_ZERO && rx_byte_i <= CH_NINE) begin
                phase_d = PH_DIG;
              end else begin
                res_o.vld      = 1'b1;
                res_o.key.kind = bracket_letter(rx_byte_i);
              end
            end else begin
              res_o.vld = 1'b1;
              if (first_q == CH_OH && rx_byte_i == 8'h48) begin
                res_o.key.kind = KEY_HOME;
              end else if (first_q == CH_OH && rx_byte_i == 8'h46) begin
                res_o.key.kind = KEY_END;
              end else begin
                res_o.key.kind = KEY_UNK3;
              end
            end
          end
          default: begin
            phase_d   = PH_IDLE;
            res_o.vld = 1'b1;
            if (rx_byte_i == CH_TILDE) begin
              res_o.key.kind = tilde_digit(second_q);
            end else begin
              res_o.key.kind = KEY_UNK3;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      first_q  <= 8'h00;
      second_q <= 8'h00;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tked_out_buf.sv =====
// two-entry result buffer between decode and the output stream
`default_nettype none

module tked_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tked_pkg::tked_res_t res_i,
  output logic                full_o,
  output logic                out_valid_o,
  output tked_pkg::tked_key_t out_key_o,
  input  logic                out_ready_i
);
  import tked_pkg::*;

  tked_key_t  mem_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       push, pop;

  assign push        = res_i.vld;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_key_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= res_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/terminal_key_escape_decoder_top.sv =====
// top level of the terminal key escape decoder
//
//   channel  | dir | tdata         | tuser
//   s_axis   | in  | rx_byte [7:0] | cmd [0]
//   m_axis   | out | key_byte[7:0] | key_kind [3:0]
//
// one beat per cycle while s_axis_tready_o is high: each input beat is decoded in the cycle it is taken
// and at most one key lands in a two-entry output buffer the next edge
// first key appears on m_axis in the cycle after the beat that completes it
// s_axis_tready_o drops only while both buffer entries wait on m_axis
// reset clears the sequence state and empties the buffer
`default_nettype none

module terminal_key_escape_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  input  logic       s_axis_tuser_i,   // [0] cmd
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] key_byte
  output logic [3:0] m_axis_tuser_o    // [3:0] key_kind
);
  import tked_pkg::*;
  `include "terminal_key_escape_decoder_top_defines.svh"

  logic      accept;
  logic      full;
  tked_res_t res;
  tked_key_t out_key;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  tked_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .timeout_i (s_axis_tuser_i),
    .rx_byte_i (s_axis_tdata_i),
    .res_o     (res)
  );

  tked_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (m_axis_tvalid_o),
    .out_key_o   (out_key),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = out_key.key_byte;
  assign m_axis_tuser_o = out_key.kind;

  `TKED_ASSERT_IMPL(a_full_has_out, !s_axis_tready_o, m_axis_tvalid_o, "full buffer without output beat")
  `TKED_ASSERT_IMPL(a_byte_only_plain, m_axis_tvalid_o && (m_axis_tuser_o != KEY_PLAIN), m_axis_tdata_o == 8'h00, "nonzero byte on non-plain key")
  `TKED_ASSERT_NEXT(a_plain_idle_out, accept && !s_axis_tuser_i && res.vld, m_axis_tvalid_o, "decoded key not presented")
  `TKED_ASSERT_IMPL(a_res_only_on_accept, res.vld, accept, "key produced without input beat")

endmodule

`default_nettype wire
